@@ rtl/mcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam int COORD_W = 11;
  localparam int DEC_W   = 14;
  localparam int COLOR_W = 8;
  localparam int OFF_W   = 16;
  localparam int NPTS    = 8;

  // Input mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Decision term constants of the midpoint rule
  localparam logic [DEC_W-1:0] DEC_INIT = 14'd3;
  localparam logic [DEC_W-1:0] DEC_DIAG = 14'd10;
  localparam logic [DEC_W-1:0] DEC_AXIS = 14'd6;

  typedef enum logic {
    JOB_STATUS = 1'b0,
    JOB_POINTS = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic                       done;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic [COLOR_W-1:0]         color;
  } job_t;

endpackage

@@ rtl/mcr_front.sv @@
// ----------------------------------------------------------------------------
// mcr_front
// Accepts start and step items, keeps the octant state and issues one job
// per item: a status word or the octant position to be expanded.
// ----------------------------------------------------------------------------
module mcr_front
  import mcr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      mode,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic [9:0]                radius,
  input  logic [COLOR_W-1:0]        color,
  output job_t                      job,
  output logic                      job_push
);

  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic [COLOR_W-1:0]        col_r, col_nxt;
  logic [COORD_W-1:0]        x_r, x_nxt;
  logic [COORD_W-1:0]        y_r, y_nxt;
  logic [DEC_W-1:0]          dec_r, dec_nxt;
  logic                      act_r, act_nxt;

  logic [COORD_W-1:0] x_step, y_step;
  logic               dec_pos;
  logic [DEC_W-1:0]   diff;
  logic [DEC_W-1:0]   dec_step;

  // y drops to -1 on the last step of a zero radius, so compare signed
  assign x_step  = x_r + 11'd1;
  assign dec_pos = ($signed(dec_r) > $signed(14'd0));
  assign y_step  = dec_pos ? (y_r - 11'd1) : y_r;
  assign diff    = DEC_W'($signed(x_step)) - DEC_W'($signed(y_step));
  assign dec_step = dec_pos ? (dec_r + (diff << 2) + DEC_DIAG)
                            : (dec_r + (DEC_W'(x_step) << 2) + DEC_AXIS);

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    col_nxt  = col_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    dec_nxt  = dec_r;
    act_nxt  = act_r;
    job      = '0;
    job.kind = JOB_STATUS;
    job_push = accept;
    if (accept) begin
      if (mode == MODE_START) begin
        cx_nxt   = center_x;
        cy_nxt   = center_y;
        col_nxt  = color;
        x_nxt    = '0;
        y_nxt    = COORD_W'(radius);
        dec_nxt  = DEC_INIT - (DEC_W'(radius) << 1);
        act_nxt  = 1'b1;
        job.done = 1'b0;
      end else if (!act_r || ($signed(x_r) > $signed(y_r))) begin
        // nothing left to draw: report done, clear the active flag, hold the rest
        act_nxt  = 1'b0;
        job.done = 1'b1;
      end else begin
        x_nxt     = x_step;
        y_nxt     = y_step;
        dec_nxt   = dec_step;
        act_nxt   = ($signed(x_step) <= $signed(y_step));
        job.kind  = JOB_POINTS;
        job.done  = ($signed(x_step) > $signed(y_step));
        job.cx    = cx_r;
        job.cy    = cy_r;
        job.x     = x_r;
        job.y     = y_r;
        job.color = col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      col_r <= '0;
      x_r   <= '0;
      y_r   <= '0;
      dec_r <= '0;
      act_r <= 1'b0;
    end else begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      col_r <= col_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      dec_r <= dec_nxt;
      act_r <= act_nxt;
    end
  end

endmodule

@@ rtl/mcr_queue.sv @@
// ----------------------------------------------------------------------------
// mcr_queue
// Short job queue that decouples the front from the pixel back end.
// ----------------------------------------------------------------------------
module mcr_queue
  import mcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == DEPTH_C);
  assign q_valid = (cnt_r != '0);
  assign rd_job  = slot_r[rp_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/mcr_back.sv @@
// ----------------------------------------------------------------------------
// mcr_back
// Expands a job into its eight symmetric points, clips them to the screen
// and writes one result word per cycle while the output register is free.
// ----------------------------------------------------------------------------
module mcr_back
  import mcr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [OFF_W-1:0]   pixel_offset,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               visible,
  output logic               last,
  output logic               done_res
);

  localparam int PW = COORD_W + 1;
  localparam int MW = 21;
  localparam logic [COORD_W-1:0] W_L = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] H_L = COORD_W'(SCREEN_HEIGHT);

  // expansion stage
  logic                 m_v_r, m_v_nxt;
  job_kind_t            m_kind_r;
  logic                 m_done_r;
  logic [COLOR_W-1:0]   m_col_r;
  logic [NPTS-1:0]      m_mask_r, m_mask_nxt;
  logic signed [PW-1:0] m_px_r [NPTS];
  logic signed [PW-1:0] m_py_r [NPTS];

  // output register
  logic               o_v_r, o_v_nxt;
  logic [OFF_W-1:0]   o_off_r;
  logic [COLOR_W-1:0] o_col_r;
  logic               o_vis_r, o_last_r, o_dn_r;

  logic signed [PW-1:0] pt_px [NPTS];
  logic signed [PW-1:0] pt_py [NPTS];
  logic [NPTS-1:0]      pt_vis;
  logic signed [PW-1:0] cxe, cye, xe, ye;

  logic                 o_free, emit, is_status, fin, load;
  logic [NPTS-1:0]      sel_bit, rest;
  logic [2:0]           sel_idx;
  logic signed [PW-1:0] sel_px, sel_py;
  logic [MW-1:0]        off_full;

  // eight symmetric points of the octant position
  assign cxe = PW'(q_job.cx);
  assign cye = PW'(q_job.cy);
  assign xe  = $signed({1'b0, q_job.x});
  assign ye  = $signed({1'b0, q_job.y});

  always_comb begin
    pt_px[0] = cxe + xe;  pt_py[0] = cye + ye;
    pt_px[1] = cxe - xe;  pt_py[1] = cye + ye;
    pt_px[2] = cxe + xe;  pt_py[2] = cye - ye;
    pt_px[3] = cxe - xe;  pt_py[3] = cye - ye;
    pt_px[4] = cxe + ye;  pt_py[4] = cye + xe;
    pt_px[5] = cxe - ye;  pt_py[5] = cye + xe;
    pt_px[6] = cxe + ye;  pt_py[6] = cye - xe;
    pt_px[7] = cxe - ye;  pt_py[7] = cye - xe;
    for (int i = 0; i < NPTS; i++) begin
      pt_vis[i] = !pt_px[i][PW-1] && (pt_px[i][COORD_W-1:0] < W_L) &&
                  !pt_py[i][PW-1] && (pt_py[i][COORD_W-1:0] < H_L);
    end
  end

  // lowest pending point goes out first
  always_comb begin
    sel_idx = '0;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (m_mask_r[i]) begin
        sel_idx = 3'(i);
      end
    end
    sel_bit = NPTS'(1) << sel_idx;
    rest    = m_mask_r & ~sel_bit;
    sel_px  = m_px_r[sel_idx];
    sel_py  = m_py_r[sel_idx];
    off_full = MW'(sel_py[9:0]) * MW'(W_L) + MW'(sel_px[9:0]);
  end

  assign o_free    = !o_v_r || pop;
  assign emit      = m_v_r && o_free;
  assign is_status = (m_kind_r == JOB_STATUS) || (m_mask_r == '0);
  assign fin       = emit && (is_status || (rest == '0));
  assign load      = q_valid && (!m_v_r || fin);
  assign q_pop     = load;

  always_comb begin
    m_v_nxt    = m_v_r;
    m_mask_nxt = m_mask_r;
    if (emit) begin
      m_mask_nxt = rest;
    end
    if (fin) begin
      m_v_nxt = 1'b0;
    end
    if (load) begin
      m_v_nxt    = 1'b1;
      m_mask_nxt = (q_job.kind == JOB_POINTS) ? pt_vis : '0;
    end
    o_v_nxt = o_v_r;
    if (pop) begin
      o_v_nxt = 1'b0;
    end
    if (emit) begin
      o_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      m_v_r <= m_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_mask_r <= m_mask_nxt;
    if (load) begin
      m_kind_r <= q_job.kind;
      m_done_r <= q_job.done;
      m_col_r  <= q_job.color;
      for (int i = 0; i < NPTS; i++) begin
        m_px_r[i] <= pt_px[i];
        m_py_r[i] <= pt_py[i];
      end
    end
    if (emit) begin
      o_dn_r <= m_done_r;
      if (is_status) begin
        o_off_r  <= '0;
        o_col_r  <= '0;
        o_vis_r  <= 1'b0;
        o_last_r <= 1'b1;
      end else begin
        o_off_r  <= off_full[OFF_W-1:0];
        o_col_r  <= m_col_r;
        o_vis_r  <= 1'b1;
        o_last_r <= (rest == '0);
      end
    end
  end

  assign empty        = !o_v_r;
  assign pixel_offset = o_off_r;
  assign pixel_color  = o_col_r;
  assign visible      = o_vis_r;
  assign last         = o_last_r;
  assign done_res     = o_dn_r;

endmodule

@@ rtl/midpoint_circle_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Midpoint circle rasterizer: one octant step per item, pixel writes out.
// ----------------------------------------------------------------------------
// Input channel: push/full. A start item (mode 0) latches center, radius and
// color and answers with one status word. A step item (mode 1) expands the
// current octant position into up to eight pixel writes (off-screen points
// dropped, duplicates kept); a step with nothing visible, or one after the
// circle is finished, answers with one status word. last marks the final
// word of each item, done_res flags a finished circle.
// Result channel: empty/pop, the oldest word sits on the out_ ports.
// Path: accept, job queue, expansion stage, output register.
// Throughput: while the receiver pops, the back end writes one word per cycle
// through a single offset multiplier; an item gives max(1, visible points)
// words, at most eight. The front takes an item every cycle while its
// four-entry job queue has room.
// Reset: clears the octant state (no circle active) and empties the queue
// and output register. When the receiver stops popping, the output word
// holds, the back end stalls, and full rises once the queue fills.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_mode,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic [9:0]                in_radius,
  input  logic [COLOR_W-1:0]        in_color,
  output logic                      empty,
  input  logic                      pop,
  output logic [OFF_W-1:0]          out_pixel_offset,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_visible,
  output logic                      out_last,
  output logic                      out_done_res
);

  job_t f_job, q_job;
  logic f_push, q_full, q_valid, q_pop;
  logic in_acc;

  assign full   = q_full;
  assign in_acc = push && !q_full;

  mcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .mode     (in_mode),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .color    (in_color),
    .job      (f_job),
    .job_push (f_push)
  );

  mcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_job  (f_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_valid (q_valid)
  );

  mcr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .pixel_offset (out_pixel_offset),
    .pixel_color  (out_pixel_color),
    .visible      (out_visible),
    .last         (out_last),
    .done_res     (out_done_res)
  );

endmodule

@@ rtl/mcr_checker.sv @@
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks for the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker
  import mcr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [OFF_W-1:0]   out_pixel_offset,
  input logic [COLOR_W-1:0] out_pixel_color,
  input logic               out_visible,
  input logic               out_last,
  input logic               out_done_res
);

  localparam int AREA      = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam bit AREA_FITS = (AREA <= 65536);

  // reset drains both sides
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue not cleared by reset");

  // a waiting word holds until taken
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_offset) &&
                          $stable(out_pixel_color) && $stable(out_visible) &&
                          $stable(out_last) && $stable(out_done_res)))
    else $error("result word changed while stalled");

  // status words are single and carry no pixel
  a_status_form : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_visible) |->
      (out_last && (out_pixel_offset == '0) && (out_pixel_color == '0)))
    else $error("malformed status word");

  // pixel writes land inside the frame buffer
  a_offset_range : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_visible && AREA_FITS) |-> (32'(out_pixel_offset) < AREA))
    else $error("pixel offset outside frame buffer");

  // a popped word that was not last is followed by more of the same item
  a_no_done_change : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) ##1 !empty |->
      (out_done_res == $past(out_done_res)) && out_visible)
    else $error("item broken up mid-stream");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_mcr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_pixel_offset (out_pixel_offset),
  .out_pixel_color  (out_pixel_color),
  .out_visible      (out_visible),
  .out_last         (out_last),
  .out_done_res     (out_done_res)
);

@@ tb/midpoint_circle_rasterizer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top_tb
// Self-checking bench for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// Drives start and step commands through the push/full port and pops pixel
// words through empty/pop. An in-bench octant tracker predicts every word
// (clipping, symmetry order, duplicates, completion flags, status words) and
// a scoreboard compares each popped word against the oldest prediction.
// Directed corner cases come first, then random circles under four idling
// mixes, with one long receiver hold-off that backs the block up to full.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top_tb;
  import mcr_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 200;
  localparam int DEC_START = 3;
  localparam int DEC_DIAG_STEP = 10;
  localparam int DEC_AXIS_STEP = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 95;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [9:0]                radius;
    logic [COLOR_W-1:0]        color;
  } circle_cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] color;
    logic               visible;
    logic               last;
    logic               done;
  } pixel_word_t;

  class circle_scoreboard;
    int           cen_col, cen_row, oct_x, oct_y, dec;
    logic [7:0]   ink;
    bit           busy;
    pixel_word_t  expected_words[$];
    int           errors, n_start, n_step, n_pixel, n_status, n_finished;

    function new();
      cen_col = 0; cen_row = 0; oct_x = 0; oct_y = 0; dec = 0;
      ink = '0; busy = 0;
      errors = 0; n_start = 0; n_step = 0; n_pixel = 0; n_status = 0;
      n_finished = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // keep the decision term in 14-bit two's complement
    function int wrap_dec(int v);
      logic signed [DEC_W-1:0] t;
      t = v[DEC_W-1:0];
      return t;
    endfunction

    function pixel_word_t status_word(bit fin);
      pixel_word_t w;
      w = '0;
      w.last = 1'b1;
      w.done = fin;
      return w;
    endfunction

    function void accept_item(circle_cmd_t c);
      int          px[8];
      int          py[8];
      int          i, kept;
      bit          fin;
      pixel_word_t w;
      if (c.mode == MODE_START) begin
        cen_col = $signed(c.cx);
        cen_row = $signed(c.cy);
        ink = c.color;
        oct_x = 0;
        oct_y = int'(c.radius);
        dec = wrap_dec(DEC_START - 2 * oct_y);
        busy = 1;
        n_start++;
        expected_words.push_back(status_word(1'b0));
        return;
      end
      n_step++;
      if (!busy || oct_x > oct_y) begin
        busy = 0;
        n_status++;
        expected_words.push_back(status_word(1'b1));
        return;
      end
      px = '{cen_col + oct_x, cen_col - oct_x, cen_col + oct_x, cen_col - oct_x,
             cen_col + oct_y, cen_col - oct_y, cen_col + oct_y, cen_col - oct_y};
      py = '{cen_row + oct_y, cen_row + oct_y, cen_row - oct_y, cen_row - oct_y,
             cen_row + oct_x, cen_row + oct_x, cen_row - oct_x, cen_row - oct_x};
      // advance the octant by the midpoint rule
      oct_x++;
      if (dec > 0) begin
        oct_y--;
        dec = wrap_dec(dec + 4 * (oct_x - oct_y) + DEC_DIAG_STEP);
      end else begin
        dec = wrap_dec(dec + 4 * oct_x + DEC_AXIS_STEP);
      end
      busy = (oct_x <= oct_y);
      fin = !busy;
      if (fin) n_finished++;
      kept = 0;
      for (i = 0; i < 8; i++) begin
        if (px[i] >= 0 && px[i] < SCR_W && py[i] >= 0 && py[i] < SCR_H) begin
          w.offset = 16'(py[i] * SCR_W + px[i]);
          w.color = ink;
          w.visible = 1'b1;
          w.last = 1'b0;
          w.done = fin;
          expected_words.push_back(w);
          kept++;
        end
      end
      n_pixel += kept;
      if (kept == 0) begin
        n_status++;
        expected_words.push_back(status_word(fin));
      end else begin
        expected_words[expected_words.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_word(pixel_word_t got);
      pixel_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected word: off=%0d col=%0d vis=%0b last=%0b done=%0b",
                   got.offset, got.color, got.visible, got.last, got.done);
        return;
      end
      want = expected_words.pop_front();
      if (got.offset !== want.offset || got.color !== want.color ||
          got.visible !== want.visible || got.last !== want.last ||
          got.done !== want.done) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected off=%0d col=%0d vis=%0b last=%0b done=%0b",
                   want.offset, want.color, want.visible, want.last, want.done);
          $display("          actual   off=%0d col=%0d vis=%0b last=%0b done=%0b",
                   got.offset, got.color, got.visible, got.last, got.done);
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic                      in_mode;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_y;
  logic [9:0]                in_radius;
  logic [COLOR_W-1:0]        in_color;
  logic                      empty;
  logic                      pop;
  logic [OFF_W-1:0]          out_pixel_offset;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic                      out_visible;
  logic                      out_last;
  logic                      out_done_res;

  circle_scoreboard sb;
  int               send_idle_pct;
  int               stall_pct;
  bit               hold_req;
  int               items_sent;
  int               cycles = 0;

  midpoint_circle_rasterizer_top #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_offset(out_pixel_offset),
    .out_pixel_color (out_pixel_color),
    .out_visible     (out_visible),
    .out_last        (out_last),
    .out_done_res    (out_done_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: stall at random, honor a hold-off request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_word('{out_pixel_offset, out_pixel_color, out_visible, out_last,
                      out_done_res});
  end

  task automatic send_cmd(circle_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_mode <= c.mode;
    in_center_x <= c.cx;
    in_center_y <= c.cy;
    in_radius <= c.radius;
    in_color <= c.color;
    // hold the word until the block takes it
    do @(posedge clk); while (full);
    sb.accept_item(c);
    items_sent++;
  endtask

  task automatic start_circle(int cx, int cy, int r, int col);
    circle_cmd_t c;
    c.mode = MODE_START;
    c.cx = cx[COORD_W-1:0];
    c.cy = cy[COORD_W-1:0];
    c.radius = r[9:0];
    c.color = col[COLOR_W-1:0];
    send_cmd(c);
  endtask

  // step words carry random junk in the start-only fields
  task automatic step_circle();
    circle_cmd_t c;
    c.mode = MODE_STEP;
    c.cx = COORD_W'($urandom_range(0, 2047));
    c.cy = COORD_W'($urandom_range(0, 2047));
    c.radius = 10'($urandom_range(0, 1023));
    c.color = 8'($urandom_range(0, 255));
    send_cmd(c);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_circle();
    circle_cmd_t c;
    int          r, cx, cy, steps, p;
    p = $urandom_range(99);
    if (p < 8) begin
      c = {1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
           11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)),
           8'($urandom_range(0, 255))};
      send_cmd(c);
      return;
    end
    p = $urandom_range(99);
    if (p < 85) r = $urandom_range(0, 40);
    else if (p < 95) r = $urandom_range(41, 200);
    else r = $urandom_range(201, 1023);
    if ($urandom_range(99) < 80) begin
      cx = int'($urandom_range(0, 400)) - 40;
      cy = int'($urandom_range(0, 280)) - 40;
    end else begin
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
    end
    start_circle(cx, cy, r, $urandom_range(0, 255));
    steps = r * 3 / 4 + 1 + $urandom_range(0, 2);
    if ($urandom_range(99) < 20) steps = $urandom_range(0, steps);
    if (steps > 60) steps = 60;
    repeat (steps) step_circle();
  endtask

  task automatic run_phase(int idle_pct, int stall, int budget);
    int stop_at;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) random_circle();
    @(negedge clk);
    push <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = MODE_START;
    in_center_x = '0;
    in_center_y = '0;
    in_radius = '0;
    in_color = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // step with no circle in progress
    step_circle();
    // zero radius: eight duplicates of the center, then done
    start_circle(0, 0, 0, 255);
    step_circle();
    step_circle();
    // extreme centers and radius, nothing on screen
    start_circle(-1024, -1024, 1023, 0);
    step_circle();
    start_circle(1023, 1023, 1023, 8'h5A);
    step_circle();
    start_circle(160, 100, 1023, 8'hA5);
    step_circle();
    // clipping at the far corner and at the origin
    start_circle(319, 199, 1, 8'h0F);
    step_circle();
    step_circle();
    start_circle(-1, -1, 3, 8'hF0);
    repeat (3) step_circle();
    // restart in the middle of a circle
    start_circle(100, 50, 12, 8'h33);
    step_circle();
    start_circle(100, 50, 2, 8'hCC);
    repeat (3) step_circle();
    @(negedge clk);
    push <= 1'b0;
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1;
    start_circle(160, 100, 30, 8'h77);
    repeat (20) step_circle();
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(80, 0, PHASE_ITEMS);
    run_phase(0, 80, PHASE_ITEMS);
    run_phase(14, 14, PHASE_ITEMS);

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;
    $display("%0d commands: %0d starts, %0d steps, %0d circles finished",
             items_sent, sb.n_start, sb.n_step, sb.n_finished);
    $display("%0d pixel words and %0d step status words checked, %0d errors",
             sb.n_pixel, sb.n_status, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
